/* sv/fxdec_pkg.sv */
// Shared constants and types for the fixed-point to decimal ASCII converter.
package fxdec_pkg;

    // Number format of the input beat.
    localparam int VALUE_W    = 48;
    localparam int FRAC_BITS  = 16;
    localparam int INT_W      = VALUE_W - FRAC_BITS;

    // Decimal text limits.
    localparam int INT_DIGITS      = 10;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int BCD_W           = 4 * INT_DIGITS;

    // Counter widths.
    localparam int CONV_CNT_W = $clog2(INT_W + 1);
    localparam int DIG_CNT_W  = $clog2(INT_DIGITS + 1);
    localparam int FRAC_CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CFG_W      = 4;

    // Width of the fraction times ten product.
    localparam int PROD_W = FRAC_BITS + 4;

    // Character codes.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Reset value of the fraction digit count register.
    localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = 4'd2;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_SIGN = 6'b000100,
        S_INT  = 6'b001000,
        S_DOT  = 6'b010000,
        S_FRAC = 6'b100000
    } state_t;

endpackage

/* sv/fixed_to_decimal_ascii.sv */
// Top level: converts one signed fixed-point number into decimal ASCII text.
//
// Usage:
//   The s_ channel takes one signed Q32.16 number per beat in s_tdata. The
//   m_ channel returns its text one character per beat: an optional '-', the
//   integer digits most significant first, '.', then the configured count of
//   truncated fraction digits. m_tlast marks the final character.
//   cfg_wen/cfg_wdata set the fraction digit count (values above 9 act as 9).
// Conversion:
//   After a beat is accepted, the integer part is converted to BCD by a
//   double-dabble shift register, one bit per cycle. Then one character
//   leaves per cycle while the output register is free; leading zero digits
//   are skipped without output, and each fraction digit takes one
//   multiply-by-ten step of the fraction register. s_tready is high only
//   between numbers.
// Reset:
//   aresetn clears the sequencer and the output valid flag and sets the
//   fraction digit count to 2.
// Stalls:
//   A character waits in the output register while m_tready is low and the
//   sequencer holds until that register is free again; nothing is lost.
module fixed_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: fraction digit count.
    input  logic        cfg_wen,
    input  logic [3:0]  cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] value
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] char_code
    output logic        m_tlast
);

    fxdec_pkg::state_t state_reg, state_next;

    logic [fxdec_pkg::CFG_W-1:0]      frac_digits_reg;
    logic                             neg_reg, neg_next;
    logic [fxdec_pkg::INT_W-1:0]      ip_reg, ip_next;
    logic [fxdec_pkg::FRAC_BITS-1:0]  fp_reg, fp_next;
    logic [fxdec_pkg::BCD_W-1:0]      bcd_reg, bcd_next;
    logic                             ovf_reg, ovf_next;
    logic                             started_reg, started_next;
    logic [fxdec_pkg::CONV_CNT_W-1:0] conv_cnt_reg, conv_cnt_next;
    logic [fxdec_pkg::DIG_CNT_W-1:0]  dig_cnt_reg, dig_cnt_next;
    logic [fxdec_pkg::FRAC_CNT_W-1:0] frac_cnt_reg, frac_cnt_next;

    logic       m_valid_reg;
    logic [7:0] m_data_reg, m_data_next;
    logic       m_last_reg, m_last_next;

    logic                             out_free;
    logic                             emit;
    logic                             in_beat;
    logic [fxdec_pkg::VALUE_W-1:0]    mag;
    logic [fxdec_pkg::BCD_W-1:0]      bcd_adj;
    logic [3:0]                       top_digit;
    logic [fxdec_pkg::PROD_W-1:0]     prod;
    logic [fxdec_pkg::FRAC_CNT_W-1:0] frac_lim;

    // Handshake and port drive.
    assign s_tready = (state_reg == fxdec_pkg::S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // Magnitude of the incoming number.
    assign mag = s_tdata[fxdec_pkg::VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;

    // Double-dabble adjust: add three to every BCD digit of five or more.
    always_comb begin
        for (int i = 0; i < fxdec_pkg::INT_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Digit sources for the integer and fraction phases.
    assign top_digit = ovf_reg ? 4'd9 : bcd_reg[fxdec_pkg::BCD_W-1 -: 4];
    assign prod = (fxdec_pkg::PROD_W'(fp_reg) << 3) + (fxdec_pkg::PROD_W'(fp_reg) << 1);
    assign frac_lim = (frac_digits_reg > fxdec_pkg::CFG_W'(fxdec_pkg::MAX_FRAC_DIGITS))
                    ? fxdec_pkg::FRAC_CNT_W'(fxdec_pkg::MAX_FRAC_DIGITS)
                    : fxdec_pkg::FRAC_CNT_W'(frac_digits_reg);

    // Sequencer next-state logic.
    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        ip_next       = ip_reg;
        fp_next       = fp_reg;
        bcd_next      = bcd_reg;
        ovf_next      = ovf_reg;
        started_next  = started_reg;
        conv_cnt_next = conv_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        frac_cnt_next = frac_cnt_reg;
        emit          = 1'b0;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            fxdec_pkg::S_IDLE: begin
                if (in_beat) begin
                    neg_next      = s_tdata[fxdec_pkg::VALUE_W-1];
                    ip_next       = mag[fxdec_pkg::VALUE_W-1:fxdec_pkg::FRAC_BITS];
                    fp_next       = mag[fxdec_pkg::FRAC_BITS-1:0];
                    bcd_next      = '0;
                    ovf_next      = 1'b0;
                    conv_cnt_next = fxdec_pkg::CONV_CNT_W'(fxdec_pkg::INT_W);
                    state_next    = fxdec_pkg::S_CONV;
                end
            end
            fxdec_pkg::S_CONV: begin
                // One integer bit enters the BCD register per cycle.
                bcd_next      = {bcd_adj[fxdec_pkg::BCD_W-2:0], ip_reg[fxdec_pkg::INT_W-1]};
                ovf_next      = ovf_reg | bcd_adj[fxdec_pkg::BCD_W-1];
                ip_next       = ip_reg << 1;
                conv_cnt_next = conv_cnt_reg - 1'b1;
                if (conv_cnt_reg == fxdec_pkg::CONV_CNT_W'(1)) begin
                    started_next = 1'b0;
                    dig_cnt_next = fxdec_pkg::DIG_CNT_W'(fxdec_pkg::INT_DIGITS);
                    state_next   = fxdec_pkg::S_SIGN;
                end
            end
            fxdec_pkg::S_SIGN: begin
                if (!neg_reg) begin
                    state_next = fxdec_pkg::S_INT;
                end else if (out_free) begin
                    emit        = 1'b1;
                    m_data_next = fxdec_pkg::CH_MINUS;
                    m_last_next = 1'b0;
                    state_next  = fxdec_pkg::S_INT;
                end
            end
            fxdec_pkg::S_INT: begin
                // Leading zeros are skipped, but the ones digit always prints.
                if (top_digit != 4'd0 || started_reg || dig_cnt_reg == fxdec_pkg::DIG_CNT_W'(1)) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        m_data_next  = fxdec_pkg::CH_ZERO + {4'd0, top_digit};
                        m_last_next  = 1'b0;
                        started_next = 1'b1;
                        bcd_next     = bcd_reg << 4;
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == fxdec_pkg::DIG_CNT_W'(1)) begin
                            state_next = fxdec_pkg::S_DOT;
                        end
                    end
                end else begin
                    bcd_next     = bcd_reg << 4;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end
            fxdec_pkg::S_DOT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    m_data_next   = fxdec_pkg::CH_DOT;
                    m_last_next   = (frac_lim == '0);
                    frac_cnt_next = frac_lim;
                    state_next    = (frac_lim == '0) ? fxdec_pkg::S_IDLE : fxdec_pkg::S_FRAC;
                end
            end
            fxdec_pkg::S_FRAC: begin
                // Each fraction digit is the integer part of the fraction times ten.
                if (out_free) begin
                    emit          = 1'b1;
                    m_data_next   = fxdec_pkg::CH_ZERO
                                  + {4'd0, prod[fxdec_pkg::PROD_W-1:fxdec_pkg::FRAC_BITS]};
                    m_last_next   = (frac_cnt_reg == fxdec_pkg::FRAC_CNT_W'(1));
                    fp_next       = prod[fxdec_pkg::FRAC_BITS-1:0];
                    frac_cnt_next = frac_cnt_reg - 1'b1;
                    if (frac_cnt_reg == fxdec_pkg::FRAC_CNT_W'(1)) begin
                        state_next = fxdec_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = fxdec_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fxdec_pkg::S_IDLE;
            m_valid_reg     <= 1'b0;
            frac_digits_reg <= fxdec_pkg::FRAC_DIGITS_RESET;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                frac_digits_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        ip_reg       <= ip_next;
        fp_reg       <= fp_next;
        bcd_reg      <= bcd_next;
        ovf_reg      <= ovf_next;
        started_reg  <= started_next;
        conv_cnt_reg <= conv_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        frac_cnt_reg <= frac_cnt_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    // Only sign, point and decimal digits ever leave the block.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg == fxdec_pkg::CH_MINUS || m_data_reg == fxdec_pkg::CH_DOT
                         || (m_data_reg >= fxdec_pkg::CH_ZERO && m_data_reg <= fxdec_pkg::CH_NINE)))
        else $error("character outside the decimal set");

    // An accepted number always starts the BCD conversion.
    a_start_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == fxdec_pkg::S_CONV))
        else $error("accepted beat did not start conversion");

    // The conversion and fraction counters never run out inside their phase.
    a_conv_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxdec_pkg::S_CONV) |-> (conv_cnt_reg != '0))
        else $error("conversion counter empty during conversion");

    a_frac_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fxdec_pkg::S_FRAC) |-> (frac_cnt_reg != '0))
        else $error("fraction counter empty during fraction digits");

    // A character is only loaded into a free output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("output register overwritten while stalled");

endmodule

/* tb/sv/tb_fixed_to_decimal_ascii.sv */
// Testbench for the fixed-point to decimal ASCII converter, with its own text predictor.
`timescale 1ns / 1ps

// One character beat of the decimal text.
typedef struct packed {
    logic       last;
    logic [7:0] code;
} text_beat_t;

// Predicts the decimal text of each accepted number and checks the characters.
class decimal_text_board;
    logic [fxdec_pkg::CFG_W-1:0] frac_digits;
    text_beat_t                  expected_text[$];
    int                          errors;

    function new();
        frac_digits = fxdec_pkg::FRAC_DIGITS_RESET;
        errors      = 0;
    endfunction

    function void set_frac_digits(logic [fxdec_pkg::CFG_W-1:0] d);
        frac_digits = d;
    endfunction

    function int pending();
        return expected_text.size();
    endfunction

    // Work out the characters of one accepted number.
    function void note_value(logic [fxdec_pkg::VALUE_W-1:0] value);
        logic [fxdec_pkg::VALUE_W-1:0] mag;
        logic [63:0]                   whole_val;
        logic [63:0]                   frac_val;
        logic [63:0]                   frac_mask;
        logic [3:0]                    digits[$];
        logic [7:0]                    codes[$];
        int                            shown;
        int                            i;

        frac_mask = (64'd1 << fxdec_pkg::FRAC_BITS) - 64'd1;
        mag       = value[fxdec_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
        whole_val = 64'(mag) >> fxdec_pkg::FRAC_BITS;
        frac_val  = 64'(mag) & frac_mask;

        if (value[fxdec_pkg::VALUE_W-1]) begin
            codes.push_back(fxdec_pkg::CH_MINUS);
        end

        // Integer digits, a single zero when the integer part is empty.
        if (whole_val == 64'd0) begin
            digits.push_front(4'd0);
        end
        while (whole_val != 64'd0) begin
            digits.push_front(4'(whole_val % 64'd10));
            whole_val = whole_val / 64'd10;
        end
        // An integer part that is too long saturates to all nines.
        if (digits.size() > fxdec_pkg::INT_DIGITS) begin
            digits.delete();
            for (i = 0; i < fxdec_pkg::INT_DIGITS; i++) begin
                digits.push_back(4'd9);
            end
        end
        foreach (digits[k]) begin
            codes.push_back(fxdec_pkg::CH_ZERO + 8'(digits[k]));
        end

        codes.push_back(fxdec_pkg::CH_DOT);

        // Truncated fraction digits, one multiply by ten each.
        shown = (frac_digits > fxdec_pkg::MAX_FRAC_DIGITS)
              ? fxdec_pkg::MAX_FRAC_DIGITS : int'(frac_digits);
        for (i = 0; i < shown; i++) begin
            frac_val = frac_val * 64'd10;
            codes.push_back(fxdec_pkg::CH_ZERO + 8'(frac_val >> fxdec_pkg::FRAC_BITS));
            frac_val = frac_val & frac_mask;
        end

        foreach (codes[k]) begin
            expected_text.push_back('{last: (k == codes.size() - 1), code: codes[k]});
        end
    endfunction

    // Compare one accepted character beat with the oldest expectation.
    function void check_char(logic [7:0] code, logic last);
        text_beat_t want;

        if (expected_text.size() == 0) begin
            $error("unexpected character beat: char_code %h last %b", code, last);
            errors++;
            return;
        end
        want = expected_text.pop_front();
        if (code !== want.code) begin
            $error("char_code mismatch: expected %h, actual %h", want.code, code);
            errors++;
        end
        if (last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, last);
            errors++;
        end
    endfunction
endclass

module tb_fixed_to_decimal_ascii;

    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = 48'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic rx_hold      = 1'b0;
    int  cycle_count   = 0;

    decimal_text_board text_board = new();

    fixed_to_decimal_ascii i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // Cycle budget for the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fixed_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            text_board.check_char(m_tdata, m_tlast);
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one number and wait until it is taken.
    task automatic send_value(logic [47:0] value);
        int gap;

        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        text_board.note_value(value);
    endtask

    // Close a run of numbers; valid goes low for at least one cycle.
    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Let all text drain, then change the fraction digit count.
    task automatic write_frac_digits(logic [3:0] d);
        while (text_board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        text_board.set_frac_digits(d);
    endtask

    // Hold the result side off for a long stretch.
    task automatic hold_receiver(int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    // Random number biased toward the interesting regions.
    function automatic logic [47:0] random_value();
        logic [63:0] r;
        logic [47:0] v;
        logic [31:0] ip;
        int          k;

        r = {$urandom(), $urandom()};
        case ($urandom_range(5))
            0: v = r[47:0];
            1: v = {{24{r[23]}}, r[23:0]};
            2: v = {r[47:16], 16'h0000};
            3: v = {{32{r[47]}}, r[15:0]};
            4: v = r[0] ? (48'h7FFF_FFFF_FFFF - 48'(r[5:1]))
                        : (48'h8000_0000_0000 + 48'(r[5:1]));
            default: begin
                // Integer parts on either side of a power of ten.
                k  = $urandom_range(9);
                ip = 32'd1;
                repeat (k) ip = ip * 32'd10;
                if (r[32]) begin
                    ip = ip - 32'd1;
                end
                v = {ip, r[15:0]};
                if (r[33]) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_value(random_value());
        end_burst();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed numbers at the reset digit count.
        send_value(48'h0000_0000_0000);  // zero
        send_value(48'hFFFF_FFFF_8000);  // minus one half keeps its sign
        send_value(48'h7FFF_FFFF_FFFF);  // largest positive
        send_value(48'h8000_0000_0000);  // most negative pattern
        send_value(48'hFFFF_FFFF_FFFF);  // smallest negative step
        send_value(48'h0000_0001_8000);  // one and a half
        send_value(48'h0000_000A_0000);  // ten
        end_burst();

        // No fraction digits: the point ends the text.
        write_frac_digits(4'd0);
        send_value(48'h0000_000C_4000);
        send_value(48'hFFFF_FFFC_4000);
        end_burst();

        // A count above the maximum acts as the maximum.
        write_frac_digits(4'd15);
        send_value(48'h0000_0000_FFFF);
        send_value(48'h8000_0000_0000);
        send_value(48'h0000_0000_0001);
        send_value(48'h7FFF_FFFF_FFFF);
        end_burst();

        write_frac_digits(4'd9);
        send_value(48'h0000_0001_FFFF);
        send_value(48'hFFFF_FFFF_FFFF);
        end_burst();

        // Random numbers, slow receiver.
        write_frac_digits(4'd3);
        send_idle_pct = 13;
        recv_idle_pct = 88;
        run_random(90);

        // Random numbers, slow sender.
        write_frac_digits(4'($urandom_range(15)));
        send_idle_pct = 88;
        recv_idle_pct = 13;
        run_random(90);

        // Full rate, with a long receiver hold-off at the start.
        write_frac_digits(4'd9);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        run_random(100);

        while (text_board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (text_board.errors == 0) begin
            $display("fixed_to_decimal_ascii regression: pass");
        end else begin
            $display("fixed_to_decimal_ascii regression: fail");
        end
        $finish;
    end

endmodule
